FILE: rtl/core/kvdf_pkg.sv
// Package for the key/value record deframer: codes, result type and CRC step.
package kvdf_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] HEADER_FIXED = 32'd12;

  // Result kinds
  localparam logic [1:0] KIND_KEY     = 2'd0;
  localparam logic [1:0] KIND_VALUE   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict codes
  localparam logic [2:0] V_OK     = 3'd0;
  localparam logic [2:0] V_SHORT  = 3'd1;
  localparam logic [2:0] V_TOTAL  = 3'd2;
  localparam logic [2:0] V_KEYLEN = 3'd3;
  localparam logic [2:0] V_VALLEN = 3'd4;
  localparam logic [2:0] V_CRC    = 3'd5;

  typedef enum logic [6:0] {
    PH_TOTAL  = 7'b000_0001,
    PH_KEYLEN = 7'b000_0010,
    PH_KEY    = 7'b000_0100,
    PH_VALLEN = 7'b000_1000,
    PH_VALUE  = 7'b001_0000,
    PH_CHECK  = 7'b010_0000,
    PH_DRAIN  = 7'b100_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] verdict;
    logic       last;
  } result_t;

  // Up to two results produced by one transaction, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/kvdf_parser.sv
// Record parser: header fields, length checks, CRC and result generation.
module kvdf_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output kvdf_pkg::result_pair_t results
);

  kvdf_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] limit_r, limit_nxt;      // total length minus twelve
  logic [31:0] val_exp_r, val_exp_nxt;  // expected value length
  logic [31:0] left_r, left_nxt;
  logic [31:0] after_r, after_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [31:0] shifted;
  logic        field_done;
  logic [31:0] crc_upd;
  logic        emit_byte;
  logic [1:0]  emit_kind;
  logic [2:0]  verdict;
  kvdf_pkg::result_t byte_res, verd_res;

  assign shifted    = {shift_r[23:0], data_byte};
  assign field_done = (idx_r == 2'd3);
  assign crc_upd    = kvdf_pkg::crc_byte(crc_r, data_byte);

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    shift_nxt   = shift_r;
    total_nxt   = total_r;
    limit_nxt   = limit_r;
    val_exp_nxt = val_exp_r;
    left_nxt    = left_r;
    after_nxt   = after_r;
    crc_nxt     = crc_r;
    err_nxt     = err_r;
    emit_byte   = 1'b0;
    emit_kind   = kvdf_pkg::KIND_KEY;

    if (phase_r == kvdf_pkg::PH_TOTAL) begin
      shift_nxt = shifted;
      idx_nxt   = idx_r + 2'd1;
      if (field_done) begin
        total_nxt = shifted;
        limit_nxt = shifted - kvdf_pkg::HEADER_FIXED;
        after_nxt = '0;
        crc_nxt   = kvdf_pkg::CRC_ALL_ONES;
        err_nxt   = kvdf_pkg::V_OK;
        if (shifted < kvdf_pkg::HEADER_FIXED) begin
          err_nxt   = kvdf_pkg::V_KEYLEN;
          phase_nxt = kvdf_pkg::PH_DRAIN;
        end else begin
          phase_nxt = kvdf_pkg::PH_KEYLEN;
        end
      end
    end else if (after_r == total_r) begin
      // byte beyond the declared total length
      err_nxt   = kvdf_pkg::V_TOTAL;
      phase_nxt = kvdf_pkg::PH_DRAIN;
    end else begin
      after_nxt = after_r + 32'd1;
      unique case (phase_r)
        kvdf_pkg::PH_KEYLEN: begin
          crc_nxt   = crc_upd;
          shift_nxt = shifted;
          idx_nxt   = idx_r + 2'd1;
          if (field_done) begin
            if (shifted > limit_r) begin
              err_nxt   = kvdf_pkg::V_KEYLEN;
              phase_nxt = kvdf_pkg::PH_DRAIN;
            end else begin
              left_nxt    = shifted;
              val_exp_nxt = limit_r - shifted;
              phase_nxt   = (shifted != '0) ? kvdf_pkg::PH_KEY : kvdf_pkg::PH_VALLEN;
            end
          end
        end
        kvdf_pkg::PH_KEY: begin
          crc_nxt   = crc_upd;
          emit_byte = 1'b1;
          emit_kind = kvdf_pkg::KIND_KEY;
          left_nxt  = left_r - 32'd1;
          if (left_r == 32'd1) phase_nxt = kvdf_pkg::PH_VALLEN;
        end
        kvdf_pkg::PH_VALLEN: begin
          crc_nxt   = crc_upd;
          shift_nxt = shifted;
          idx_nxt   = idx_r + 2'd1;
          if (field_done) begin
            if (shifted != val_exp_r) begin
              err_nxt   = kvdf_pkg::V_VALLEN;
              phase_nxt = kvdf_pkg::PH_DRAIN;
            end else begin
              left_nxt  = shifted;
              phase_nxt = (shifted != '0) ? kvdf_pkg::PH_VALUE : kvdf_pkg::PH_CHECK;
            end
          end
        end
        kvdf_pkg::PH_VALUE: begin
          crc_nxt   = crc_upd;
          emit_byte = 1'b1;
          emit_kind = kvdf_pkg::KIND_VALUE;
          left_nxt  = left_r - 32'd1;
          if (left_r == 32'd1) phase_nxt = kvdf_pkg::PH_CHECK;
        end
        kvdf_pkg::PH_CHECK: begin
          shift_nxt = shifted;
          idx_nxt   = idx_r + 2'd1;
          if (field_done) begin
            if ((crc_r ^ kvdf_pkg::CRC_ALL_ONES) != shifted) err_nxt = kvdf_pkg::V_CRC;
            phase_nxt = kvdf_pkg::PH_DRAIN;
          end
        end
        default: phase_nxt = kvdf_pkg::PH_DRAIN;
      endcase
    end
  end

  // Verdict from the state after this byte
  always_comb begin
    if (phase_nxt == kvdf_pkg::PH_TOTAL) begin
      verdict = kvdf_pkg::V_SHORT;
    end else if (err_nxt == kvdf_pkg::V_TOTAL || after_nxt != total_nxt) begin
      verdict = kvdf_pkg::V_TOTAL;
    end else begin
      verdict = err_nxt;
    end
  end

  always_comb begin
    byte_res.data    = data_byte;
    byte_res.kind    = emit_kind;
    byte_res.verdict = kvdf_pkg::V_OK;
    byte_res.last    = 1'b0;
    verd_res.data    = 8'd0;
    verd_res.kind    = kvdf_pkg::KIND_VERDICT;
    verd_res.verdict = verdict;
    verd_res.last    = 1'b1;

    results.count  = {1'b0, emit_byte} + {1'b0, last_byte};
    results.first  = emit_byte ? byte_res : verd_res;
    results.second = verd_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && last_byte)) begin
      phase_r   <= kvdf_pkg::PH_TOTAL;
      idx_r     <= '0;
      shift_r   <= '0;
      total_r   <= '0;
      limit_r   <= '0;
      val_exp_r <= '0;
      left_r    <= '0;
      after_r   <= '0;
      crc_r     <= kvdf_pkg::CRC_ALL_ONES;
      err_r     <= kvdf_pkg::V_OK;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      shift_r   <= shift_nxt;
      total_r   <= total_nxt;
      limit_r   <= limit_nxt;
      val_exp_r <= val_exp_nxt;
      left_r    <= left_nxt;
      after_r   <= after_nxt;
      crc_r     <= crc_nxt;
      err_r     <= err_nxt;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_byte) |=> (phase_r == kvdf_pkg::PH_TOTAL && idx_r == 2'd0))
    else $error("parser did not restart after record end");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (results.count == 2'd2) |-> (results.first.kind != kvdf_pkg::KIND_VERDICT
                                 && results.second.kind == kvdf_pkg::KIND_VERDICT))
    else $error("byte result must precede verdict");

  a_after_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != kvdf_pkg::PH_TOTAL) |-> (after_r <= total_r))
    else $error("byte count passed total length");

endmodule

FILE: rtl/core/kvdf_out_queue.sv
// Four-entry result queue: up to two pushes per cycle, one pop.
module kvdf_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  kvdf_pkg::result_pair_t push_data,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output kvdf_pkg::result_t      head_data
);

  kvdf_pkg::result_t q_r [4];
  logic [1:0] head_r, head_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] push_n;
  logic [1:0] tail0, tail1;
  logic       pop;

  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign head_data = q_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign push_n    = push ? push_data.count : 2'd0;
  assign tail0     = head_r + cnt_r[1:0];
  assign tail1     = tail0 + 2'd1;
  assign head_nxt  = head_r + {1'b0, pop};
  assign cnt_nxt   = cnt_r + {1'b0, push_n} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[tail0] <= push_data.first;
    if (push_n == 2'd2) q_r[tail1] <= push_data.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room)
    else $error("push without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_n == 2'd0) |=> (cnt_r == $past(cnt_r) - 3'd1))
    else $error("pop did not lower count");

endmodule

FILE: rtl/core/kv_record_deframer_checker_unit.sv
// Top level of the key/value record deframer and CRC-32 checker.
// Path: a record byte goes through the input register, then the result queue;
//   the verdict follows the same path.
// Throughput: one input transaction per cycle while in_stall is low; the output
//   drains one result per cycle unless stalled; a last key/value byte makes two.
// Reset: synchronous active-low rst_n empties the pipeline and queue and puts
//   the parser back to waiting for the total length field.
module kv_record_deframer_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [2:0] out_verdict,
  output logic       out_last_out
);

  // Input register stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  logic                   room;
  logic                   adv;
  logic                   accept;
  kvdf_pkg::result_pair_t results;
  kvdf_pkg::result_t      head;

  // The parser consumes the registered byte only when the queue can take two
  // results; room comes from the queue count alone, so stall is registered.
  assign adv          = s1_valid_r && room;
  assign in_stall     = s1_valid_r && !room;
  assign accept       = in_valid && !in_stall;
  assign s1_valid_nxt = accept || (s1_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  kvdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .results   (results)
  );

  kvdf_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .push_data (results),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_data (head)
  );

  assign out_byte     = head.data;
  assign out_kind     = head.kind;
  assign out_verdict  = head.verdict;
  assign out_last_out = head.last;

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid))
    else $error("input stalled with empty queue");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_data_r) && $stable(s1_last_r)))
    else $error("pending input item lost");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == kvdf_pkg::KIND_VERDICT) == out_last_out))
    else $error("verdict and last flag disagree");

endmodule
